// File: sv/lis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

  localparam int VALUE_BITS = 10;
  localparam int MAX_ITEMS  = 4096;
  localparam int COUNT_BITS = 32;

  localparam int LEN_BITS  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_BITS = VALUE_BITS + 1;
  localparam int NODES     = 2 ** ADDR_BITS;

  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [ADDR_BITS-1:0]  idx_t;

  typedef struct packed {
    len_t len;
    cnt_t cnt;
  } node_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    node_t data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LEAFRD,
    S_QUERY,
    S_QTAIL,
    S_LEAF,
    S_UPDATE,
    S_EMIT
  } state_t;

  // An empty subtree: no subsequence, counted as one empty way.
  localparam node_t EMPTY_NODE = '{len: '0, cnt: cnt_t'(1)};
  localparam idx_t  ROOT_IDX   = idx_t'(1);
  localparam len_t  LEN_MAX    = len_t'(MAX_ITEMS);

endpackage

`default_nettype wire

// File: sv/lis_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module lis_merge (
  input  lis_pkg::node_t a,
  input  lis_pkg::node_t b,
  output lis_pkg::node_t y
);

  logic [lis_pkg::COUNT_BITS:0] sum;

  assign sum = {1'b0, a.cnt} + {1'b0, b.cnt};

  always_comb begin
    if (a.len == b.len) begin
      if (a.len == '0) begin
        y = lis_pkg::EMPTY_NODE;
      end else begin
        y.len = a.len;
        // A carry out means the count has passed the top of its range.
        y.cnt = sum[lis_pkg::COUNT_BITS] ? '1 : sum[lis_pkg::COUNT_BITS-1:0];
      end
    end else if (a.len > b.len) begin
      y = a;
    end else begin
      y = b;
    end
  end

endmodule

`default_nettype wire

// File: sv/lis_tree_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lis_tree_mem (
  input  logic             clk,
  input  lis_pkg::mem_wr_t wr,
  input  lis_pkg::idx_t    rd_addr,
  output lis_pkg::node_t   rd_data
);

  lis_pkg::node_t mem [lis_pkg::NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/lis_length_and_count_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// input    in_valid / in_ready    value, start_req
// output   out_valid / out_ready  ending_length, ending_count, best_length, best_count
//
// A transaction makes a read per tree level for the prefix query, then a read and a write
// per level to rebuild the ancestors; in_ready returns in the same cycle that the result
// is loaded into the output register. A start_req transaction first sweeps the tree,
// clearing every node, and the same sweep runs after reset with in_ready low. A result
// waits in the output register while the next transaction runs; the next result holds
// until that register is free.

module lis_length_and_count_tracker_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lis_pkg::VALUE_BITS-1:0] value,
  input  logic                           start_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lis_pkg::LEN_BITS-1:0]   ending_length,
  output logic [lis_pkg::COUNT_BITS-1:0] ending_count,
  output logic [lis_pkg::LEN_BITS-1:0]   best_length,
  output logic [lis_pkg::COUNT_BITS-1:0] best_count
);

  lis_pkg::state_t  state, state_next;
  lis_pkg::idx_t    walk, clr_addr, leaf_idx, rd_addr;
  lis_pkg::node_t   acc, leaf_reg, cur, end_pair, root_pair, q_pair;
  lis_pkg::node_t   mg_a, mg_b, mg_y, rd_data;
  lis_pkg::mem_wr_t mem_wr;
  logic [lis_pkg::VALUE_BITS-1:0] v_reg;
  logic pending, rd_leaf, rd_merge, can_load;

  assign leaf_idx = {1'b1, v_reg};
  assign can_load = !out_valid || out_ready;
  assign q_pair.len = (acc.len < lis_pkg::LEN_MAX) ? acc.len + lis_pkg::len_t'(1) : acc.len;
  assign q_pair.cnt = acc.cnt;

  lis_merge u_merge (
    .a (mg_a),
    .b (mg_b),
    .y (mg_y)
  );

  lis_tree_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      lis_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = start_req ? lis_pkg::S_CLEAR : lis_pkg::S_LEAFRD;
        end
      end
      lis_pkg::S_CLEAR: begin
        if (&clr_addr) begin
          state_next = pending ? lis_pkg::S_LEAFRD : lis_pkg::S_IDLE;
        end
      end
      lis_pkg::S_LEAFRD: state_next = lis_pkg::S_QUERY;
      lis_pkg::S_QUERY: begin
        if ((walk >> 1) == lis_pkg::ROOT_IDX) begin
          state_next = lis_pkg::S_QTAIL;
        end
      end
      lis_pkg::S_QTAIL: state_next = lis_pkg::S_LEAF;
      lis_pkg::S_LEAF:  state_next = lis_pkg::S_UPDATE;
      lis_pkg::S_UPDATE: begin
        if (walk == lis_pkg::ROOT_IDX) begin
          state_next = lis_pkg::S_EMIT;
        end
      end
      lis_pkg::S_EMIT: begin
        if (can_load) begin
          state_next = lis_pkg::S_IDLE;
        end
      end
      default: state_next = lis_pkg::S_IDLE;
    endcase
  end

  // The memory port always reads the sibling of the current node unless told otherwise.
  always_comb begin
    in_ready = 1'b0;
    mem_wr   = '{en: 1'b0, addr: walk, data: mg_y};
    rd_addr  = walk ^ lis_pkg::ROOT_IDX;
    mg_a     = acc;
    mg_b     = rd_data;
    unique case (state)
      lis_pkg::S_IDLE:   in_ready = 1'b1;
      lis_pkg::S_CLEAR:  mem_wr = '{en: 1'b1, addr: clr_addr, data: lis_pkg::EMPTY_NODE};
      lis_pkg::S_LEAFRD: rd_addr = leaf_idx;
      lis_pkg::S_LEAF: begin
        mg_a    = q_pair;
        mg_b    = leaf_reg;
        mem_wr  = '{en: 1'b1, addr: leaf_idx, data: mg_y};
        rd_addr = leaf_idx ^ lis_pkg::ROOT_IDX;
      end
      lis_pkg::S_UPDATE: begin
        mg_a      = cur;
        mem_wr.en = 1'b1;
      end
      lis_pkg::S_QUERY, lis_pkg::S_QTAIL, lis_pkg::S_EMIT: begin
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lis_pkg::S_CLEAR;
      clr_addr  <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      rd_leaf   <= 1'b0;
      rd_merge  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_leaf  <= (state == lis_pkg::S_LEAFRD);
      // Only a left sibling lies below the value, so merge it when the node is a right child.
      rd_merge <= (state == lis_pkg::S_QUERY) && walk[0];
      if ((state == lis_pkg::S_EMIT) && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lis_pkg::S_IDLE: begin
          if (in_valid) begin
            v_reg    <= value;
            pending  <= start_req;
            clr_addr <= '0;
            acc      <= lis_pkg::EMPTY_NODE;
            walk     <= {1'b1, value};
          end
        end
        lis_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + lis_pkg::ROOT_IDX;
          if (&clr_addr) begin
            pending <= 1'b0;
          end
        end
        lis_pkg::S_QUERY: begin
          walk <= walk >> 1;
          if (rd_leaf) begin
            leaf_reg <= rd_data;
          end
          if (rd_merge) begin
            acc <= mg_y;
          end
        end
        lis_pkg::S_QTAIL: begin
          if (rd_merge) begin
            acc <= mg_y;
          end
        end
        lis_pkg::S_LEAF: begin
          end_pair <= q_pair;
          cur      <= mg_y;
          walk     <= leaf_idx >> 1;
        end
        lis_pkg::S_UPDATE: begin
          cur  <= mg_y;
          walk <= walk >> 1;
          if (walk == lis_pkg::ROOT_IDX) begin
            root_pair <= mg_y;
          end
        end
        lis_pkg::S_EMIT: begin
          if (can_load) begin
            ending_length <= end_pair.len;
            ending_count  <= end_pair.cnt;
            best_length   <= root_pair.len;
            best_count    <= root_pair.cnt;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/lis_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lis_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lis_pkg::LEN_BITS-1:0]   ending_length,
  input logic [lis_pkg::COUNT_BITS-1:0] ending_count,
  input logic [lis_pkg::LEN_BITS-1:0]   best_length,
  input logic [lis_pkg::COUNT_BITS-1:0] best_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ending_length) &&
      $stable(ending_count) && $stable(best_length) && $stable(best_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in progress");

  a_ending_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ending_length != '0 && ending_count != '0)
    else $error("empty ending result");

  a_best_covers_ending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_length >= ending_length)
    else $error("overall best shorter than this transaction's length");

endmodule

bind lis_length_and_count_tracker_unit lis_checker u_lis_checker (.*);

`default_nettype wire
